/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the pattern generator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rtpg_pkg.sv */
// ---------------------------------------------------------------------------
// RGB test pattern generator package
// Widths, constants, shared types and helper functions of the generator.
// ---------------------------------------------------------------------------
package rtpg_pkg;

  // Field widths.
  localparam int unsigned FN_W      = 64;
  localparam int unsigned PIX_W     = 12;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned CFG_IDX_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_FRAME_HEIGHT = 4'd1;

  // Reset values and parameter defaults.
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Bar layer.
  localparam int unsigned NUM_BARS   = 8;
  localparam int unsigned BAR_IDX_W  = 3;
  localparam int unsigned BAR_THR_W  = DIM_W + 3;

  // Box layer.
  localparam int unsigned BOX_MIN     = 8;
  localparam int unsigned BW_W        = DIM_W - 3;
  localparam int unsigned BH_W        = 11;
  localparam int unsigned BOT_W       = DIM_W + 1;
  localparam logic [COLOR_W-1:0] BOX_LEVEL = 8'd16;
  // Division by six as a multiply by a rounded-up reciprocal.
  localparam int unsigned DIV6_MUL    = 10923;
  localparam int unsigned DIV6_SHIFT  = 16;
  localparam int unsigned H6P_W       = DIM_W + DIV6_SHIFT;

  // Frame number squares.
  localparam int unsigned SQ_COLS       = 16;
  localparam int unsigned SQ_ROWS       = 2;
  localparam int unsigned SQ_SIDE_SHIFT = 7;
  localparam int unsigned SIDE_W        = DIM_W - SQ_SIDE_SHIFT;
  localparam int unsigned PITCH_W       = SIDE_W + 1;
  localparam int unsigned SQ_POS_W      = 11;
  localparam int unsigned SQ_ORIGIN     = 2;
  localparam logic [COLOR_W-1:0] SQ_ON  = 8'd255;
  localparam logic [COLOR_W-1:0] SQ_OFF = 8'd0;

  // One pixel color.
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rtpg_rgb_t;

  // Frame geometry derived from the size registers.
  typedef struct packed {
    logic [DIM_W-1:0]                         width;
    logic [DIM_W-1:0]                         height;
    logic [NUM_BARS-2:0][BAR_THR_W-1:0]       bar_thr;
    logic [BW_W-1:0]                          box_w;
    logic [DIM_W-1:0]                         travel;
    logic [DIM_W-1:0]                         box_top;
    logic [BOT_W-1:0]                         box_bot;
    logic [SQ_COLS-1:0][SQ_POS_W-1:0]         sq_start;
    logic [SQ_COLS-1:0][SQ_POS_W-1:0]         sq_stop;
  } rtpg_geom_t;

  // Sum of two residues, reduced once more by the modulus.
  function automatic logic [DIM_W-1:0] add_mod(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b,
                                               input logic [DIM_W-1:0] m);
    logic [DIM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[DIM_W-1:0];
  endfunction

  // Color of each vertical bar, left to right.
  function automatic rtpg_rgb_t bar_color(input logic [BAR_IDX_W-1:0] idx);
    rtpg_rgb_t c;
    case (idx)
      3'd0:    c = '{8'd255, 8'd255, 8'd255};
      3'd1:    c = '{8'd255, 8'd255, 8'd0};
      3'd2:    c = '{8'd0,   8'd255, 8'd255};
      3'd3:    c = '{8'd0,   8'd255, 8'd0};
      3'd4:    c = '{8'd255, 8'd0,   8'd255};
      3'd5:    c = '{8'd255, 8'd0,   8'd0};
      3'd6:    c = '{8'd0,   8'd0,   8'd255};
      default: c = '{8'd32,  8'd32,  8'd32};
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/rtpg_setup.sv */
// ---------------------------------------------------------------------------
// Pattern geometry setup
// Holds the size registers, derives the layer geometry from them and fills
// the table of 2^k mod travel used to place the box.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rtpg_setup #(
  parameter int unsigned MAX_WIDTH  = rtpg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rtpg_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [rtpg_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [rtpg_pkg::DIM_W-1:0]                    cfg_data,
  output logic                                          ready,
  output rtpg_pkg::rtpg_geom_t                          geom,
  output logic [rtpg_pkg::FN_W-1:0][rtpg_pkg::DIM_W-1:0] residue
);
  import rtpg_pkg::*;

  typedef enum logic [2:0] {
    ST_SETTLE = 3'b001,
    ST_TABLE  = 3'b010,
    ST_RUN    = 3'b100
  } setup_state_t;

  // Cycles for the derived geometry chain to settle after a size change.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned TABLE_LEN     = FN_W;
  localparam int unsigned CNT_W         = $clog2(TABLE_LEN);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > hi) begin
      r = DIM_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic                   cfg_fire;
  logic [DIM_W-1:0]       frame_width_r;
  logic [DIM_W-1:0]       frame_height_r;
  setup_state_t           state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [DIM_W-1:0]       cur_r;
  logic [FN_W-1:0][DIM_W-1:0] res_r;

  logic [DIM_W-1:0]       w_c_r;
  logic [DIM_W-1:0]       h_c_r;
  logic [DIM_W-1:0]       min_dim;
  logic [BW_W-1:0]        box_w_r;
  logic [H6P_W-1:0]       h6p_r;
  logic [SIDE_W-1:0]      side_r;
  logic [NUM_BARS-2:0][BAR_THR_W-1:0] bar_thr_r;
  logic [DIM_W-1:0]       travel_r;
  logic [DIM_W:0]         box_w_plus;
  logic [DIM_W-1:0]       h_div6;
  logic [BH_W-1:0]        box_h_r;
  logic [PITCH_W-1:0]     pitch;
  logic [SQ_COLS-1:0][SQ_POS_W-1:0] sq_start_r;
  logic [SQ_COLS-1:0][SQ_POS_W-1:0] sq_stop_r;
  logic [DIM_W-1:0]       box_top_r;
  logic [BOT_W-1:0]       box_bot_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // First geometry step: clamped frame size.
  always_ff @(posedge clk) begin
    w_c_r <= clamp_dim(frame_width_r, MAX_WIDTH);
    h_c_r <= clamp_dim(frame_height_r, MAX_HEIGHT);
  end

  assign min_dim = (w_c_r < h_c_r) ? w_c_r : h_c_r;

  // Second step: box width, height product, square side and bar thresholds.
  always_ff @(posedge clk) begin
    if (w_c_r[DIM_W-1:3] < BW_W'(BOX_MIN)) begin
      box_w_r <= BW_W'(BOX_MIN);
    end else begin
      box_w_r <= w_c_r[DIM_W-1:3];
    end
    h6p_r <= H6P_W'(h_c_r) * H6P_W'(DIV6_MUL);
    if (min_dim[DIM_W-1:SQ_SIDE_SHIFT] == '0) begin
      side_r <= SIDE_W'(1);
    end else begin
      side_r <= min_dim[DIM_W-1:SQ_SIDE_SHIFT];
    end
    for (int k = 1; k < NUM_BARS; k++) begin
      bar_thr_r[k-1] <= BAR_THR_W'(k) * BAR_THR_W'(w_c_r);
    end
  end

  assign box_w_plus = (DIM_W+1)'(box_w_r) + (DIM_W+1)'(1);
  assign h_div6     = h6p_r[DIV6_SHIFT +: DIM_W];
  assign pitch      = PITCH_W'(side_r) + PITCH_W'(1);

  // Third step: box travel, box height and square positions.
  always_ff @(posedge clk) begin
    if ({1'b0, w_c_r} > box_w_plus) begin
      travel_r <= w_c_r - DIM_W'(box_w_r);
    end else begin
      travel_r <= DIM_W'(1);
    end
    if (h_div6 < DIM_W'(BOX_MIN)) begin
      box_h_r <= BH_W'(BOX_MIN);
    end else begin
      box_h_r <= h_div6[BH_W-1:0];
    end
    for (int c = 0; c < SQ_COLS; c++) begin
      sq_start_r[c] <= SQ_POS_W'(SQ_ORIGIN) + SQ_POS_W'(c) * SQ_POS_W'(pitch);
      sq_stop_r[c]  <= SQ_POS_W'(SQ_ORIGIN) + SQ_POS_W'(c) * SQ_POS_W'(pitch)
                       + SQ_POS_W'(side_r);
    end
  end

  // Fourth and fifth steps: vertically centered box top and bottom.
  always_ff @(posedge clk) begin
    if (h_c_r > DIM_W'(box_h_r)) begin
      box_top_r <= (h_c_r - DIM_W'(box_h_r)) >> 1;
    end else begin
      box_top_r <= '0;
    end
    box_bot_r <= BOT_W'(box_top_r) + BOT_W'(box_h_r);
  end

  // Sequencer: wait for the geometry, then fill the residue table.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_fire) begin
      state_r <= ST_SETTLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_SETTLE: begin
          if (cnt_r == CNT_W'(SETTLE_CYCLES - 1)) begin
            state_r <= ST_TABLE;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_TABLE: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(TABLE_LEN - 1)) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: ;
        default: state_r <= ST_SETTLE;
      endcase
    end
  end

  // Residue datapath: cur holds 2^k mod travel while the table fills.
  always_ff @(posedge clk) begin
    if (state_r == ST_SETTLE) begin
      cur_r <= (travel_r == DIM_W'(1)) ? '0 : DIM_W'(1);
    end else if (state_r == ST_TABLE) begin
      res_r[cnt_r] <= cur_r;
      cur_r        <= add_mod(cur_r, cur_r, travel_r);
    end
  end

  assign ready   = (state_r == ST_RUN);
  assign residue = res_r;

  always_comb begin
    geom          = '0;
    geom.width    = w_c_r;
    geom.height   = h_c_r;
    geom.bar_thr  = bar_thr_r;
    geom.box_w    = box_w_r;
    geom.travel   = travel_r;
    geom.box_top  = box_top_r;
    geom.box_bot  = box_bot_r;
    geom.sq_start = sq_start_r;
    geom.sq_stop  = sq_stop_r;
  end

  // Checks.
  `RTPG_ASSERT_IMP(a_res_bound, clk, rst_n, state_r == ST_TABLE, cur_r < travel_r, "residue out of range")
  `RTPG_ASSERT_NXT(a_cfg_restart, clk, rst_n, cfg_fire, state_r == ST_SETTLE && cnt_r == '0, "write did not restart setup")
  `RTPG_ASSERT_NXT(a_table_done, clk, rst_n, state_r == ST_TABLE && cnt_r == CNT_W'(TABLE_LEN - 1) && !cfg_fire, ready, "setup did not finish")

endmodule

/* hw/rtl/rgb_test_pattern_generator_top.sv */
// ---------------------------------------------------------------------------
// RGB test pattern generator
// Color bars with a moving dark box and frame number squares, one pixel per
// item, through a four stage pipeline.
// ---------------------------------------------------------------------------
//  Channel | Dir | Handshake              | Payload
//  in      | in  | in_valid / in_ready    | frame_number, pixel_x, pixel_y
//  out     | out | out_valid / out_ready  | red, green, blue
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while out_ready stays high; an accepted item is
// registered in part1_r, part2_r, left_r and rgb_r, in that order, before it
// shows on out_valid. The box position is a 64-bit modulo built as a sum of
// table residues, reduced by a tree that spans the first three stages. After
// reset and after every cfg write, in_ready stays low while the geometry settles
// and the residue table fills. Each stage holds its item while the next one is
// full and stalled, so a stall on out lets earlier stages fill empty slots.
`include "assert_macros.svh"

module rgb_test_pattern_generator_top #(
  parameter int unsigned MAX_WIDTH  = rtpg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rtpg_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rtpg_pkg::FN_W-1:0]        in_frame_number,
  input  logic [rtpg_pkg::PIX_W-1:0]       in_pixel_x,
  input  logic [rtpg_pkg::PIX_W-1:0]       in_pixel_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rtpg_pkg::COLOR_W-1:0]     out_red,
  output logic [rtpg_pkg::COLOR_W-1:0]     out_green,
  output logic [rtpg_pkg::COLOR_W-1:0]     out_blue,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtpg_pkg::DIM_W-1:0]       cfg_data
);
  import rtpg_pkg::*;

  localparam int unsigned NUM_STAGES = 4;
  localparam int unsigned PART1_N    = FN_W / 4;
  localparam int unsigned PART2_N    = PART1_N / 4;

  // Per-pixel facts that ride along with the modulo tree.
  typedef struct packed {
    logic [PIX_W-1:0]     x;
    logic                 outside;
    logic [BAR_IDX_W-1:0] bar_idx;
    logic                 box_y;
    logic                 sq_hit;
    logic                 sq_white;
  } pix_info_t;

  rtpg_geom_t                 geom;
  logic [FN_W-1:0][DIM_W-1:0] res_tbl;
  logic                       setup_ready;

  logic [NUM_STAGES-1:0]      v_r;
  logic [NUM_STAGES:0]        en;
  logic                       in_fire;

  logic [FN_W-1:0][DIM_W-1:0]      leaf;
  logic [FN_W/2-1:0][DIM_W-1:0]    lvl_a;
  logic [PART1_N-1:0][DIM_W-1:0]   part1_c;
  logic [PART1_N-1:0][DIM_W-1:0]   part1_r;
  logic [PART1_N/2-1:0][DIM_W-1:0] lvl_b;
  logic [PART2_N-1:0][DIM_W-1:0]   part2_c;
  logic [PART2_N-1:0][DIM_W-1:0]   part2_r;
  logic [PART2_N/2-1:0][DIM_W-1:0] lvl_c;
  logic [DIM_W-1:0]                left_c;
  logic [DIM_W-1:0]                left_r;

  logic [SQ_COLS-1:0]         sq_col_hit;
  logic [SQ_ROWS-1:0]         sq_row_hit;
  logic [BAR_THR_W-1:0]       x_times8;
  pix_info_t                  info_c;
  pix_info_t                  info0_r;
  pix_info_t                  info1_r;
  pix_info_t                  info2_r;

  logic                       box_x;
  logic [BOT_W-1:0]           box_right;
  rtpg_rgb_t                  pix_c;
  rtpg_rgb_t                  rgb_r;

  rtpg_setup #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ready     (setup_ready),
    .geom      (geom),
    .residue   (res_tbl)
  );

  // Stage enables: a stage loads when it is empty or its successor moves.
  always_comb begin
    en[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0] && setup_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid && setup_ready;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 0: residue selection, first two tree levels, frame, bar, box row and square tests.
  always_comb begin
    for (int k = 0; k < FN_W; k++) begin
      leaf[k] = in_frame_number[k] ? res_tbl[k] : '0;
    end
    for (int k = 0; k < FN_W / 2; k++) begin
      lvl_a[k] = add_mod(leaf[2*k], leaf[2*k+1], geom.travel);
    end
    for (int k = 0; k < PART1_N; k++) begin
      part1_c[k] = add_mod(lvl_a[2*k], lvl_a[2*k+1], geom.travel);
    end
  end

  assign x_times8 = BAR_THR_W'({in_pixel_x, 3'b000});

  always_comb begin
    info_c         = '0;
    info_c.x       = in_pixel_x;
    info_c.outside = ({1'b0, in_pixel_x} >= geom.width) ||
                     ({1'b0, in_pixel_y} >= geom.height);
    // The bar index counts the thresholds k*width that 8*x has reached.
    for (int k = 0; k < NUM_BARS - 1; k++) begin
      if (x_times8 >= geom.bar_thr[k]) begin
        info_c.bar_idx = info_c.bar_idx + BAR_IDX_W'(1);
      end
    end
    info_c.box_y = ({1'b0, in_pixel_y} >= geom.box_top) &&
                   (BOT_W'(in_pixel_y) < geom.box_bot);
    for (int c = 0; c < SQ_COLS; c++) begin
      sq_col_hit[c] = (in_pixel_x >= PIX_W'(geom.sq_start[c])) &&
                      (in_pixel_x < PIX_W'(geom.sq_stop[c]));
    end
    for (int r = 0; r < SQ_ROWS; r++) begin
      sq_row_hit[r] = (in_pixel_y >= PIX_W'(geom.sq_start[r])) &&
                      (in_pixel_y < PIX_W'(geom.sq_stop[r]));
    end
    info_c.sq_hit   = (|sq_col_hit) && (|sq_row_hit);
    info_c.sq_white = sq_row_hit[0] ? |(sq_col_hit & in_frame_number[SQ_COLS-1:0])
                                    : |(sq_col_hit & in_frame_number[2*SQ_COLS-1:SQ_COLS]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      part1_r <= part1_c;
      info0_r <= info_c;
    end
  end

  // Stage 1: two more tree levels.
  always_comb begin
    for (int k = 0; k < PART1_N / 2; k++) begin
      lvl_b[k] = add_mod(part1_r[2*k], part1_r[2*k+1], geom.travel);
    end
    for (int k = 0; k < PART2_N; k++) begin
      part2_c[k] = add_mod(lvl_b[2*k], lvl_b[2*k+1], geom.travel);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      part2_r <= part2_c;
      info1_r <= info0_r;
    end
  end

  // Stage 2: last two tree levels give the box left edge.
  always_comb begin
    for (int k = 0; k < PART2_N / 2; k++) begin
      lvl_c[k] = add_mod(part2_r[2*k], part2_r[2*k+1], geom.travel);
    end
    left_c = add_mod(lvl_c[0], lvl_c[1], geom.travel);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      left_r  <= left_c;
      info2_r <= info1_r;
    end
  end

  // Stage 3: layer the bars, the box and the squares into the output color; black outside the frame.
  assign box_right = BOT_W'(left_r) + BOT_W'(geom.box_w);
  assign box_x     = ({1'b0, info2_r.x} >= left_r) && (BOT_W'(info2_r.x) < box_right);

  always_comb begin
    pix_c = bar_color(info2_r.bar_idx);
    if (box_x && info2_r.box_y) begin
      pix_c = '{BOX_LEVEL, BOX_LEVEL, BOX_LEVEL};
    end
    if (info2_r.sq_hit) begin
      pix_c = info2_r.sq_white ? '{SQ_ON, SQ_ON, SQ_ON} : '{SQ_OFF, SQ_OFF, SQ_OFF};
    end
    if (info2_r.outside) begin
      pix_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rgb_r <= pix_c;
    end
  end

  assign out_valid = v_r[NUM_STAGES-1];
  assign out_red   = rgb_r.red;
  assign out_green = rgb_r.green;
  assign out_blue  = rgb_r.blue;

  // Checks.
  `RTPG_ASSERT_IMP(a_left_range, clk, rst_n, v_r[2], left_r < geom.travel, "box left edge not reduced")
  `RTPG_ASSERT_IMP(a_sq_single, clk, rst_n, in_fire, $onehot0(sq_col_hit), "pixel in two squares")
  `RTPG_ASSERT_NXT(a_accept_loads, clk, rst_n, in_fire, v_r[0], "accepted item not captured")

endmodule

/* test/tb_rgb_test_pattern_generator_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the RGB test pattern generator
// Drives pixel coordinates and frame numbers over a range of frame sizes and
// compares every returned color with a predictor of the bar, box and square
// layers. Both channels idle and stall at random, with one long output stall.
// ---------------------------------------------------------------------------
module tb_rgb_test_pattern_generator_top;
  import rtpg_pkg::*;

  localparam int unsigned MAX_W        = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H        = MAX_HEIGHT_DEF;
  localparam int unsigned NUM_PHASES   = 11;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_REPORTS  = 100;

  // Indexes past the register list; writes to them must leave the frame size unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_REG_SPARE_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_SPARE_HI = 4'd15;

  // Frame sizes per phase; the last two phases draw their own sizes.
  localparam int unsigned PHASE_W [NUM_PHASES] =
    '{4096, 1920, 1, 0, 8191, 5, 16, 130, 4096, 0, 0};
  localparam int unsigned PHASE_H [NUM_PHASES] =
    '{4096, 1080, 1, 0, 8191, 3, 16, 4096, 200, 0, 0};

  // Expected colors of accepted pixels, with a private copy of the sizes.
  class pixel_scoreboard;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    rtpg_rgb_t        bar_rgb [NUM_BARS];
    rtpg_rgb_t        color_q [$];
    int unsigned      errors;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      bar_rgb[0] = '{8'd255, 8'd255, 8'd255};
      bar_rgb[1] = '{8'd255, 8'd255, 8'd0};
      bar_rgb[2] = '{8'd0,   8'd255, 8'd255};
      bar_rgb[3] = '{8'd0,   8'd255, 8'd0};
      bar_rgb[4] = '{8'd255, 8'd0,   8'd255};
      bar_rgb[5] = '{8'd255, 8'd0,   8'd0};
      bar_rgb[6] = '{8'd0,   8'd0,   8'd255};
      bar_rgb[7] = '{8'd32,  8'd32,  8'd32};
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      if (idx == CFG_REG_FRAME_WIDTH) begin
        width_reg = data;
      end else if (idx == CFG_REG_FRAME_HEIGHT) begin
        height_reg = data;
      end
    endfunction

    // A size of zero acts as one, and sizes past the maximum are capped.
    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (32'(v) > hi) return hi;
      return 32'(v);
    endfunction

    function int unsigned eff_width();
      return clamp_dim(width_reg, MAX_W);
    endfunction

    function int unsigned eff_height();
      return clamp_dim(height_reg, MAX_H);
    endfunction

    function rtpg_rgb_t predict_color(logic [FN_W-1:0] fn, logic [PIX_W-1:0] px,
                                      logic [PIX_W-1:0] py);
      int unsigned w, h, x, y, idx, bw, bh, travel, left, top;
      int unsigned side, pitch, col, row, bit_idx;
      rtpg_rgb_t c;
      w = eff_width();
      h = eff_height();
      x = 32'(px);
      y = 32'(py);
      // Pixels outside the active frame are black.
      if (x >= w || y >= h) return '0;

      // Vertical bars.
      idx = (x * 8) / w;
      if (idx > NUM_BARS - 1) idx = NUM_BARS - 1;
      c = bar_rgb[idx];

      // Dark box, moving with the frame number.
      bw = w / 8;
      bh = h / 6;
      if (bw < 8) bw = 8;
      if (bh < 8) bh = 8;
      travel = (w > bw + 1) ? w - bw : 1;
      left   = 32'(fn % 64'(travel));
      top    = (h > bh) ? (h - bh) / 2 : 0;
      if (x >= left && x < left + bw && y >= top && y < top + bh) begin
        c = '{8'd16, 8'd16, 8'd16};
      end

      // Squares that show the low 32 bits of the frame number.
      side = ((w < h) ? w : h) / 128;
      if (side < 1) side = 1;
      pitch = side + 1;
      if (x >= 2 && y >= 2) begin
        col = (x - 2) / pitch;
        row = (y - 2) / pitch;
        if (col < 16 && row < 2 && (x - 2) % pitch < side && (y - 2) % pitch < side) begin
          bit_idx = row * 16 + col;
          c = fn[bit_idx] ? '{8'd255, 8'd255, 8'd255} : '{8'd0, 8'd0, 8'd0};
        end
      end
      return c;
    endfunction

    function void note_input(logic [FN_W-1:0] fn, logic [PIX_W-1:0] x,
                             logic [PIX_W-1:0] y);
      color_q.push_back(predict_color(fn, x, y));
    endfunction

    function int unsigned pending();
      return color_q.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      if (errors < MAX_REPORTS) begin
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      errors++;
    endtask

    task check_result(rtpg_rgb_t got);
      rtpg_rgb_t want;
      if (color_q.size() == 0) begin
        report_mismatch("pixel with no item pending", int'(got), 0);
        return;
      end
      want = color_q.pop_front();
      if (got.red !== want.red) report_mismatch("red", int'(got.red), int'(want.red));
      if (got.green !== want.green) begin
        report_mismatch("green", int'(got.green), int'(want.green));
      end
      if (got.blue !== want.blue) report_mismatch("blue", int'(got.blue), int'(want.blue));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [FN_W-1:0]      in_frame_number;
  logic [PIX_W-1:0]     in_pixel_x;
  logic [PIX_W-1:0]     in_pixel_y;
  logic                 out_valid;
  logic                 out_ready;
  logic [COLOR_W-1:0]   out_red;
  logic [COLOR_W-1:0]   out_green;
  logic [COLOR_W-1:0]   out_blue;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  pixel_scoreboard sb = new();
  bit              idling_on = 1'b1;
  bit              long_hold_req = 1'b0;
  int unsigned     quiet_cycles = 0;

  rgb_test_pattern_generator_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frame_number (in_frame_number),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run ends when no item moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned draw_gap();
    return idling_on ? $urandom_range(0, 15) : 0;
  endfunction

  // Offer one pixel after a random gap and wait until it is taken.
  task automatic send_pixel(input logic [FN_W-1:0] fn, input logic [PIX_W-1:0] x,
                            input logic [PIX_W-1:0] y);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_frame_number <= fn;
    in_pixel_x      <= x;
    in_pixel_y      <= y;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(fn, x, y);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering pixels until every expected color has come back.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Receiver: random stall before each item, or one long hold when asked.
  initial begin : receiver
    int unsigned stall;
    bit long_hold_done;
    rtpg_rgb_t got;
    long_hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      if (long_hold_req && !long_hold_done) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{out_red, out_green, out_blue};
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned w, h, side, wv, hv, ph, k;
    int yi;
    logic [FN_W-1:0] fn;
    logic [PIX_W-1:0] x, y;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_frame_number = '0;
    in_pixel_x      = '0;
    in_pixel_y      = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_REG_FRAME_WIDTH;
    cfg_data        = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels at the reset size of 640 x 480: squares of side 3,
    // box 80 x 80 with its top at line 200 and a travel of 560.
    send_pixel(64'd0, 12'd0, 12'd0);
    send_pixel('1, 12'd2, 12'd2);
    send_pixel('1, 12'd5, 12'd2);
    send_pixel(64'h8000_0000, 12'd62, 12'd6);
    send_pixel(64'h7FFF_FFFF, 12'd62, 12'd6);
    send_pixel(64'h0001_0000, 12'd2, 12'd6);
    send_pixel(64'd0, 12'd65, 12'd2);
    send_pixel('1, 12'd66, 12'd2);
    send_pixel(64'd0, 12'd0, 12'd200);
    send_pixel(64'd0, 12'd79, 12'd279);
    send_pixel(64'd0, 12'd80, 12'd200);
    send_pixel(64'd0, 12'd0, 12'd280);
    send_pixel(64'd559, 12'd559, 12'd240);
    send_pixel(64'd559, 12'd639, 12'd240);
    // Pixels outside the frame, and the last one inside it.
    send_pixel('1, 12'd640, 12'd0);
    send_pixel('1, 12'd0, 12'd480);
    send_pixel('1, 12'd4095, 12'd4095);
    send_pixel(64'd0, 12'd639, 12'd479);
    // First pixel of each bar.
    for (k = 1; k < NUM_BARS; k++) begin
      send_pixel(64'd0, PIX_W'(k * 80), 12'd100);
    end
    drain_pixels();

    // Random phases, one frame size each.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph >= NUM_PHASES - 2) begin
        wv = $urandom_range(1, MAX_W);
        hv = $urandom_range(1, MAX_H);
      end else begin
        wv = PHASE_W[ph];
        hv = PHASE_H[ph];
      end
      write_reg(CFG_REG_FRAME_WIDTH, DIM_W'(wv));
      write_reg(CFG_REG_FRAME_HEIGHT, DIM_W'(hv));
      if (ph == 2) begin
        write_reg(CFG_REG_SPARE_LO, DIM_W'($urandom));
        write_reg(CFG_REG_SPARE_HI, '1);
      end
      // Some phases run without gaps; one of them holds the output off.
      idling_on = (ph % 4 != 1);
      if (ph == 1) long_hold_req = 1'b1;

      w    = sb.eff_width();
      h    = sb.eff_height();
      side = ((w < h) ? w : h) / 128 + 1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        fn = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          // Noise anywhere in the coordinate range.
          0: begin
            x = PIX_W'($urandom);
            y = PIX_W'($urandom);
          end
          // Around the frame number squares.
          1, 2: begin
            x = PIX_W'($urandom_range(0, (w < 4 + 16 * (side + 1)) ? w - 1
                                                                   : 4 + 16 * (side + 1)));
            y = PIX_W'($urandom_range(0, (h < 4 + 2 * (side + 1)) ? h - 1
                                                                  : 4 + 2 * (side + 1)));
          end
          // Around the box edges, with a small frame number.
          3, 4: begin
            fn = FN_W'($urandom_range(0, w + 16));
            x  = PIX_W'((fn + FN_W'($urandom_range(0, w / 8 + 10))) % FN_W'(w));
            yi = int'(h / 2 + $urandom_range(0, h / 6 + 10) - (h / 12 + 5));
            if (yi < 0) yi = 0;
            if (yi >= int'(h)) yi = int'(h) - 1;
            y = PIX_W'(yi);
          end
          default: begin
            x = PIX_W'($urandom_range(0, w - 1));
            y = PIX_W'($urandom_range(0, h - 1));
          end
        endcase
        send_pixel(fn, x, y);
      end
      drain_pixels();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/rtpg_pkg.sv
hw/rtl/rtpg_setup.sv
hw/rtl/rgb_test_pattern_generator_top.sv
test/tb_rgb_test_pattern_generator_top.sv
